// ----- rtl/core/object_stream_memory_loader_defines.svh -----
// ----------------------------------------------------------------------------
// Object stream memory loader assertion macros
// Shared assertion forms for the checker of the loader.
// ----------------------------------------------------------------------------
`ifndef OBJECT_STREAM_MEMORY_LOADER_DEFINES_SVH
`define OBJECT_STREAM_MEMORY_LOADER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define OSML_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define OSML_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/osml_pkg.sv -----
// ----------------------------------------------------------------------------
// Object stream memory loader package
// Types and constants shared by the loader modules.
// ----------------------------------------------------------------------------
`default_nettype none

package osml_pkg;

    localparam int ADDRESS_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH          = 4;
    localparam int QUEUE_PTR_BITS       = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] DIR_CODE     = 16'hCADE;
    localparam logic [15:0] DIR_DATA     = 16'hDADA;
    localparam logic [15:0] DIR_SYMBOL   = 16'hC3B7;
    localparam logic [15:0] DIR_FILENAME = 16'hF17E;
    localparam logic [15:0] DIR_LINENUM  = 16'h715E;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_TRUNC = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_DIR_HI  = 3'd0,
        PH_DIR_LO  = 3'd1,
        PH_HDR_HI  = 3'd2,
        PH_HDR_LO  = 3'd3,
        PH_BODY_HI = 3'd4,
        PH_BODY_LO = 3'd5,
        PH_SKIP    = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] write_address;
        logic [15:0] write_data;
    } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/osml_front.sv -----
// ----------------------------------------------------------------------------
// Object stream memory loader front end
// Parses the byte stream and turns each accepted byte into at most one
// result transaction for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module osml_front
    import osml_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      accept,
    input  wire in_item_t  byte_item,
    output logic           push,
    output out_item_t      push_item
);

    phase_t                    phase_reg, phase_next;
    logic [7:0]                held_reg, held_next;
    logic [15:0]               dir_reg, dir_next;
    logic [ADDRESS_BITS-1:0]   addr_reg, addr_next;
    logic [15:0]               count_reg, count_next;
    logic [1:0]                hidx_reg, hidx_next;

    logic [15:0]               word;
    logic [15:0]               count_dec;
    logic [15:0]               count_hdr;
    logic [ADDRESS_BITS-1:0]   addr_hdr;
    logic [1:0]                hidx_inc;
    logic [1:0]                hdr_words;
    logic                      dir_known;

    assign word      = {held_reg, byte_item.stream_byte};
    assign count_dec = count_reg - 16'd1;
    assign hidx_inc  = hidx_reg + 2'd1;
    assign hdr_words = (dir_reg == DIR_FILENAME) ? 2'd1 :
                       (dir_reg == DIR_LINENUM)  ? 2'd3 : 2'd2;
    assign dir_known = (word == DIR_CODE) || (word == DIR_DATA) ||
                       (word == DIR_SYMBOL) || (word == DIR_FILENAME) ||
                       (word == DIR_LINENUM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DIR_HI;
            held_reg  <= '0;
            dir_reg   <= '0;
            addr_reg  <= '0;
            count_reg <= '0;
            hidx_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            dir_reg   <= dir_next;
            addr_reg  <= addr_next;
            count_reg <= count_next;
            hidx_reg  <= hidx_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        dir_next   = dir_reg;
        addr_next  = addr_reg;
        count_next = count_reg;
        hidx_next  = hidx_reg;
        count_hdr  = count_reg;
        addr_hdr   = addr_reg;
        push       = 1'b0;
        push_item  = '{kind: KIND_WRITE, write_address: 16'd0, write_data: 16'd0};

        if (accept)
        begin
            if (byte_item.stream_end)
            begin
                push = 1'b1;
                push_item.kind = (phase_reg == PH_HDR_HI || phase_reg == PH_HDR_LO) ?
                                 KIND_TRUNC : KIND_DONE;
                phase_next = PH_DIR_HI;
                held_next  = '0;
                dir_next   = '0;
                addr_next  = '0;
                count_next = '0;
                hidx_next  = '0;
            end
            else
            begin
                unique case (phase_reg) inside
                    PH_DIR_LO:
                    begin
                        if (dir_known)
                        begin
                            dir_next   = word;
                            hidx_next  = '0;
                            phase_next = PH_HDR_HI;
                        end
                        else
                        begin
                            phase_next = PH_DIR_HI;
                        end
                    end
                    PH_HDR_HI, PH_BODY_HI:
                    begin
                        held_next  = byte_item.stream_byte;
                        phase_next = (phase_reg == PH_HDR_HI) ? PH_HDR_LO : PH_BODY_LO;
                    end
                    PH_HDR_LO:
                    begin
                        if (dir_reg == DIR_FILENAME)
                        begin
                            count_hdr = word;
                        end
                        else if (dir_reg != DIR_LINENUM)
                        begin
                            if (hidx_reg == 2'd0)
                                addr_hdr = word[ADDRESS_BITS-1:0];
                            else
                                count_hdr = word;
                        end
                        addr_next  = addr_hdr;
                        count_next = count_hdr;
                        if (hidx_inc >= hdr_words)
                        begin
                            hidx_next = '0;
                            if (dir_reg == DIR_LINENUM || count_hdr == 16'd0)
                                phase_next = PH_DIR_HI;
                            else if (dir_reg == DIR_CODE || dir_reg == DIR_DATA)
                                phase_next = PH_BODY_HI;
                            else
                                phase_next = PH_SKIP;
                        end
                        else
                        begin
                            hidx_next  = hidx_inc;
                            phase_next = PH_HDR_HI;
                        end
                    end
                    PH_BODY_LO:
                    begin
                        push                    = 1'b1;
                        push_item.kind          = KIND_WRITE;
                        push_item.write_address = 16'(addr_reg);
                        push_item.write_data    = word;
                        addr_next  = addr_reg + ADDRESS_BITS'(1);
                        count_next = count_dec;
                        phase_next = (count_dec == 16'd0) ? PH_DIR_HI : PH_BODY_HI;
                    end
                    PH_SKIP:
                    begin
                        count_next = count_dec;
                        if (count_dec == 16'd0)
                            phase_next = PH_DIR_HI;
                    end
                    default:
                    begin
                        held_next  = byte_item.stream_byte;
                        phase_next = PH_DIR_LO;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/osml_queue.sv -----
// ----------------------------------------------------------------------------
// Object stream memory loader queue
// Short first-in first-out buffer of result transactions between the front
// end and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module osml_queue
    import osml_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire out_item_t push_item,
    input  wire logic      pop,
    output logic           full,
    output logic           nonempty,
    output out_item_t      head_item
);

    out_item_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign nonempty  = (cnt_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QUEUE_PTR_BITS'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QUEUE_CNT_BITS'(push) - QUEUE_CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/osml_back.sv -----
// ----------------------------------------------------------------------------
// Object stream memory loader output stage
// Moves queued result transactions into the output register and holds each
// one until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module osml_back
    import osml_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      head_valid,
    input  wire out_item_t head_item,
    output logic           pop,
    input  wire logic      result_stall,
    output logic           result_valid,
    output out_item_t      result_item
);

    logic      valid_reg, valid_next;
    out_item_t item_reg;

    assign pop          = head_valid && (!valid_reg || !result_stall);
    assign valid_next   = pop || (valid_reg && result_stall);
    assign result_valid = valid_reg;
    assign result_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= head_item;
    end

endmodule

`default_nettype wire

// ----- rtl/core/object_stream_memory_loader.sv -----
// ----------------------------------------------------------------------------
// Object stream memory loader
// Parses an object-file byte stream and issues memory write, completion and
// truncation transactions.
//
//   Channel   Direction  Handshake            Payload
//   byte      input      byte_valid/stall     in_item_t (stream_byte, stream_end)
//   result    output     result_valid/stall   out_item_t (kind, address, data)
//
// One byte per cycle unless stalled; each result is queued, then registered out.
// The byte side stalls only while the four-entry result queue is full.
// Reset returns the parser to expecting a directive and empties the queue.
// A stalled receiver holds the output register; the queue absorbs the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module object_stream_memory_loader
    import osml_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    output logic           byte_stall,
    input  wire in_item_t  byte_item,
    output logic           result_valid,
    input  wire logic      result_stall,
    output out_item_t      result_item
);

    logic      accept;
    logic      push;
    out_item_t push_item;
    logic      pop;
    logic      full;
    logic      nonempty;
    out_item_t head_item;

    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    osml_front #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .byte_item (byte_item),
        .push      (push),
        .push_item (push_item)
    );

    osml_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (full),
        .nonempty  (nonempty),
        .head_item (head_item)
    );

    osml_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (nonempty),
        .head_item    (head_item),
        .pop          (pop),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_item  (result_item)
    );

endmodule

`default_nettype wire

// ----- rtl/core/osml_checker.sv -----
// ----------------------------------------------------------------------------
// Object stream memory loader checker
// Port-level assertions on the loader's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "object_stream_memory_loader_defines.svh"

module osml_checker
    import osml_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      result_valid,
    input wire logic      result_stall,
    input wire out_item_t result_item
);

    `OSML_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result_item), "stalled result transaction changed")
    `OSML_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !result_valid, "result valid during reset")
    `OSML_ASSERT(a_status_zero, result_valid && result_item.kind != KIND_WRITE |-> result_item.write_address == 16'd0 && result_item.write_data == 16'd0, "status transaction carries address or data")
    `OSML_ASSERT(a_addr_range, result_valid |-> (32'(result_item.write_address) >> ADDRESS_BITS) == 32'd0, "write address exceeds address width")

endmodule

bind object_stream_memory_loader osml_checker #(.ADDRESS_BITS(ADDRESS_BITS)) u_checker (.*);

`default_nettype wire

// ----- tb/object_stream_memory_loader_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Object stream memory loader testbench
// Feeds object-file byte streams, first a few hand-built sections and then
// random well-formed sections mixed with noise, truncated headers and early
// end markers. A parser that tracks the stream in step with the block
// predicts every memory write, completion and truncation transaction, and
// each result is checked field by field in order. Both channels idle at
// random, apart from one stretch of full-rate traffic.
// ----------------------------------------------------------------------------

module object_stream_memory_loader_tb;

    import osml_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    class section_parser;
        localparam int ADDR_MASK = (1 << ADDRESS_BITS_DEFAULT) - 1;

        phase_t      phase;
        logic [7:0]  held;
        logic [15:0] directive;
        logic [15:0] next_addr;
        logic [15:0] remaining;
        logic [1:0]  field_idx;
        out_item_t   pending_loads[$];
        int          mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            phase     = PH_DIR_HI;
            held      = 8'h00;
            directive = 16'h0000;
            next_addr = 16'h0000;
            remaining = 16'h0000;
            field_idx = 2'd0;
        endfunction

        function void take_byte(in_item_t t);
            logic [15:0] word;
            out_item_t   res;
            int          idx;
            int          needed;
            word = {held, t.stream_byte};
            res.write_address = 16'h0000;
            res.write_data    = 16'h0000;
            if (t.stream_end)
            begin
                if (phase == PH_HDR_HI || phase == PH_HDR_LO)
                    res.kind = KIND_TRUNC;
                else
                    res.kind = KIND_DONE;
                pending_loads.push_back(res);
                clear();
                return;
            end
            case (phase)
                PH_DIR_LO:
                begin
                    if (word == DIR_CODE || word == DIR_DATA || word == DIR_SYMBOL ||
                        word == DIR_FILENAME || word == DIR_LINENUM)
                    begin
                        directive = word;
                        field_idx = 2'd0;
                        phase     = PH_HDR_HI;
                    end
                    else
                    begin
                        phase = PH_DIR_HI;
                    end
                end
                PH_HDR_HI:
                begin
                    held  = t.stream_byte;
                    phase = PH_HDR_LO;
                end
                PH_HDR_LO:
                begin
                    idx = int'(field_idx);
                    if (directive == DIR_FILENAME)
                        remaining = word;
                    else if (directive != DIR_LINENUM)
                    begin
                        if (idx == 0)
                            next_addr = 16'(int'(word) & ADDR_MASK);
                        else
                            remaining = word;
                    end
                    if (directive == DIR_FILENAME)
                        needed = 1;
                    else if (directive == DIR_LINENUM)
                        needed = 3;
                    else
                        needed = 2;
                    if (idx + 1 >= needed)
                    begin
                        field_idx = 2'd0;
                        if (directive == DIR_LINENUM || remaining == 16'h0000)
                            phase = PH_DIR_HI;
                        else if (directive == DIR_CODE || directive == DIR_DATA)
                            phase = PH_BODY_HI;
                        else
                            phase = PH_SKIP;
                    end
                    else
                    begin
                        field_idx = 2'(idx + 1);
                        phase     = PH_HDR_HI;
                    end
                end
                PH_BODY_HI:
                begin
                    held  = t.stream_byte;
                    phase = PH_BODY_LO;
                end
                PH_BODY_LO:
                begin
                    res.kind          = KIND_WRITE;
                    res.write_address = next_addr;
                    res.write_data    = word;
                    pending_loads.push_back(res);
                    next_addr = 16'((int'(next_addr) + 1) & ADDR_MASK);
                    remaining = remaining - 16'd1;
                    if (remaining == 16'h0000)
                        phase = PH_DIR_HI;
                    else
                        phase = PH_BODY_HI;
                end
                PH_SKIP:
                begin
                    remaining = remaining - 16'd1;
                    if (remaining == 16'h0000)
                        phase = PH_DIR_HI;
                end
                default:
                begin
                    held  = t.stream_byte;
                    phase = PH_DIR_LO;
                end
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_loads.size() == 0)
            begin
                $error("unexpected transaction: kind %0d, write_address %h, write_data %h",
                       got.kind, got.write_address, got.write_data);
                mismatches++;
                return;
            end
            want = pending_loads.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                mismatches++;
            end
            if (got.write_address !== want.write_address)
            begin
                $error("write_address: expected %h, actual %h",
                       want.write_address, got.write_address);
                mismatches++;
            end
            if (got.write_data !== want.write_data)
            begin
                $error("write_data: expected %h, actual %h", want.write_data, got.write_data);
                mismatches++;
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_item_t  byte_item;
    logic      result_valid;
    logic      result_stall;
    out_item_t result_item;

    int            cycle_count = 0;
    in_item_t      byte_stream[$];
    section_parser parser;

    object_stream_memory_loader #(
        .ADDRESS_BITS(ADDRESS_BITS_DEFAULT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .byte_item(byte_item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_item(result_item)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("object_stream_memory_loader: mismatch");
            $finish;
        end
    end

    function automatic bit idle_roll();
        if (cycle_count >= 300 && cycle_count < 900)
            return 1'b0;
        return $urandom_range(0, 99) < 28;
    endfunction

    function automatic void push_byte(logic [7:0] b);
        in_item_t t;
        t.stream_byte = b;
        t.stream_end  = 1'b0;
        byte_stream.push_back(t);
    endfunction

    function automatic void push_word(logic [15:0] w);
        push_byte(w[15:8]);
        push_byte(w[7:0]);
    endfunction

    function automatic void push_end();
        in_item_t t;
        t.stream_byte = 8'($urandom);
        t.stream_end  = 1'b1;
        byte_stream.push_back(t);
    endfunction

    task automatic build_random_stream(int target);
        logic [7:0]  sec[$];
        logic [15:0] dir;
        logic [15:0] count;
        logic [15:0] addr;
        int          pick;
        int          body_len;
        int          keep;
        bit          chop;
        while (byte_stream.size() < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                push_end();
            else if (pick < 16)
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
            else
            begin
                case ($urandom_range(0, 9)) inside
                    [0:2]:   dir = DIR_CODE;
                    [3:5]:   dir = DIR_DATA;
                    6:       dir = DIR_SYMBOL;
                    7:       dir = DIR_FILENAME;
                    8:       dir = DIR_LINENUM;
                    default: dir = 16'($urandom);
                endcase
                count = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 8))
                                                     : 16'($urandom);
                addr = ($urandom_range(0, 3) == 0) ? 16'hFFF8 + 16'($urandom_range(0, 7))
                                                   : 16'($urandom);
                sec = {};
                sec.push_back(dir[15:8]);
                sec.push_back(dir[7:0]);
                body_len = 0;
                if (dir == DIR_CODE || dir == DIR_DATA || dir == DIR_SYMBOL)
                begin
                    sec.push_back(addr[15:8]);
                    sec.push_back(addr[7:0]);
                end
                if (dir == DIR_CODE || dir == DIR_DATA || dir == DIR_SYMBOL ||
                    dir == DIR_FILENAME)
                begin
                    sec.push_back(count[15:8]);
                    sec.push_back(count[7:0]);
                    body_len = (dir == DIR_CODE || dir == DIR_DATA) ? 2 * int'(count)
                                                                    : int'(count);
                end
                else if (dir == DIR_LINENUM)
                begin
                    repeat (6) sec.push_back(8'($urandom));
                end
                chop = 1'b0;
                if (body_len > 32)
                begin
                    body_len = $urandom_range(0, 12);
                    chop     = 1'b1;
                end
                repeat (body_len) sec.push_back(8'($urandom));
                keep = sec.size();
                if (!chop && $urandom_range(0, 9) == 0)
                begin
                    keep = $urandom_range(1, sec.size() - 1);
                    chop = 1'b1;
                end
                for (int i = 0; i < keep; i++)
                    push_byte(sec[i]);
                if (chop)
                    push_end();
            end
        end
    endtask

    task automatic send_stream();
        int load_idx;
        bit presenting;
        bit took;
        bit done;
        load_idx   = 0;
        presenting = 1'b0;
        took       = 1'b0;
        done       = 1'b0;
        while (!done)
        begin
            @(negedge clk);
            if (!presenting || took)
            begin
                if (load_idx >= byte_stream.size())
                begin
                    byte_valid <= 1'b0;
                    done = 1'b1;
                end
                else
                begin
                    presenting = !idle_roll();
                    if (presenting)
                    begin
                        byte_item <= byte_stream[load_idx];
                        load_idx++;
                    end
                    byte_valid <= presenting;
                end
            end
            if (!done)
            begin
                @(posedge clk);
                took = presenting && !byte_stall;
                if (took)
                    parser.take_byte(byte_item);
            end
        end
    endtask

    task automatic drain_results();
        forever
        begin
            @(negedge clk);
            result_stall <= idle_roll();
            @(posedge clk);
            if (result_valid && !result_stall)
                parser.check_result(result_item);
        end
    endtask

    initial
    begin
        parser = new();
        rst_n        <= 1'b0;
        byte_valid   <= 1'b0;
        byte_item    <= '0;
        result_stall <= 1'b0;

        push_end();
        push_word(DIR_CODE);
        push_word(16'hFFFF);
        push_word(16'h0002);
        push_word(16'h0000);
        push_word(16'hFFFF);
        push_word(DIR_DATA);
        push_word(16'h1234);
        push_word(16'h0000);
        push_end();
        push_word(DIR_LINENUM);
        push_word(16'h00FF);
        push_end();
        push_word(DIR_CODE);
        push_end();
        push_byte(8'hAB);
        push_end();
        build_random_stream(byte_stream.size() + 600);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        fork
            drain_results();
        join_none
        send_stream();
        while (parser.pending_loads.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (parser.mismatches == 0)
            $display("object_stream_memory_loader: match");
        else
            $display("object_stream_memory_loader: mismatch");
        $finish;
    end

endmodule
